[hw/rtl/lzdec_pkg.sv]
// ----------------------------------------------------------------------------
// lzdec_pkg
// Shared types and constants for the LZ77 token stream decoder.
// ----------------------------------------------------------------------------
package lzdec_pkg;

	localparam int DEF_HISTORY_DEPTH    = 65536;
	localparam int DEF_BYTES_PER_RESULT = 4;
	localparam int MAX_LANES            = 4;

	// offset vs. produced-count arithmetic (16-bit offset, count up to 65536)
	localparam int CMP_W = 17;

	localparam int CMD_FIFO_DEPTH = 4;

	localparam logic [7:0] TAG_LITERAL = 8'h00;
	localparam logic [7:0] TAG_MATCH   = 8'h01;

	typedef enum logic [2:0] {
		PH_TAG,
		PH_LIT,
		PH_OFF_LO,
		PH_OFF_HI,
		PH_LEN
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_BAD_TAG,
		ST_TRUNC,
		ST_BAD_REF
	} status_t;

	typedef enum logic [1:0] {
		CMD_NOP,
		CMD_LIT,
		CMD_MATCH,
		CMD_FAULT
	} cmd_kind_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_EXEC,
		BK_COPY
	} back_state_t;

	// one decoded token handed from parser to copy engine
	typedef struct packed {
		cmd_kind_t   kind;
		logic [7:0]  data;    // literal byte or match length
		logic [15:0] offset;
		status_t     status;
		logic        eos;
	} cmd_t;

endpackage

[hw/rtl/lzdec_ram.sv]
// ----------------------------------------------------------------------------
// lzdec_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lzdec_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hw/rtl/lzdec_front.sv]
// ----------------------------------------------------------------------------
// lzdec_front
// Token parser: takes one stream byte per transfer, tracks the token phase
// and hands complete tokens and faults to the command queue.
// ----------------------------------------------------------------------------
module lzdec_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        in_byte,
	input  logic              end_of_stream,
	output logic              push,
	output lzdec_pkg::cmd_t   push_cmd,
	input  logic              fifo_full
);

	lzdec_pkg::phase_t phase_q, phase_d;
	logic              halted_q, halted_d;
	logic [7:0]        off_lo_q, off_lo_d;
	logic [7:0]        off_hi_q, off_hi_d;
	logic              accept;
	logic              need_cmd;

	assign in_stall = fifo_full;
	assign accept   = in_valid && !fifo_full;
	assign push     = accept && need_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= lzdec_pkg::PH_TAG;
			halted_q <= 1'b0;
			off_lo_q <= '0;
			off_hi_q <= '0;
		end else if (accept) begin
			phase_q  <= phase_d;
			halted_q <= halted_d;
			off_lo_q <= off_lo_d;
			off_hi_q <= off_hi_d;
		end
	end

	always_comb begin
		phase_d  = phase_q;
		halted_d = halted_q;
		off_lo_d = off_lo_q;
		off_hi_d = off_hi_q;
		need_cmd = 1'b0;

		push_cmd.kind   = lzdec_pkg::CMD_NOP;
		push_cmd.data   = in_byte;
		push_cmd.offset = {off_hi_q, off_lo_q};
		push_cmd.status = lzdec_pkg::ST_OK;
		push_cmd.eos    = end_of_stream;

		if (halted_q) begin
			// back end still has to restart its window on end of stream
			need_cmd = end_of_stream;
		end else begin
			unique case (phase_q)
				lzdec_pkg::PH_TAG: begin
					if (in_byte == lzdec_pkg::TAG_LITERAL) begin
						phase_d = lzdec_pkg::PH_LIT;
					end else if (in_byte == lzdec_pkg::TAG_MATCH) begin
						phase_d = lzdec_pkg::PH_OFF_LO;
					end else begin
						halted_d        = 1'b1;
						need_cmd        = 1'b1;
						push_cmd.kind   = lzdec_pkg::CMD_FAULT;
						push_cmd.status = lzdec_pkg::ST_BAD_TAG;
					end
				end
				lzdec_pkg::PH_LIT: begin
					need_cmd      = 1'b1;
					push_cmd.kind = lzdec_pkg::CMD_LIT;
					phase_d       = lzdec_pkg::PH_TAG;
				end
				lzdec_pkg::PH_OFF_LO: begin
					off_lo_d = in_byte;
					phase_d  = lzdec_pkg::PH_OFF_HI;
				end
				lzdec_pkg::PH_OFF_HI: begin
					off_hi_d = in_byte;
					phase_d  = lzdec_pkg::PH_LEN;
				end
				lzdec_pkg::PH_LEN: begin
					need_cmd      = 1'b1;
					push_cmd.kind = lzdec_pkg::CMD_MATCH;
					phase_d       = lzdec_pkg::PH_TAG;
				end
				default: begin
					phase_d = lzdec_pkg::PH_TAG;
				end
			endcase

			// token left open at end of stream
			if (end_of_stream && !halted_d && phase_d != lzdec_pkg::PH_TAG) begin
				need_cmd        = 1'b1;
				push_cmd.kind   = lzdec_pkg::CMD_FAULT;
				push_cmd.status = lzdec_pkg::ST_TRUNC;
			end
		end

		if (end_of_stream) begin
			phase_d  = lzdec_pkg::PH_TAG;
			halted_d = 1'b0;
			off_lo_d = '0;
			off_hi_d = '0;
		end
	end

endmodule

[hw/rtl/lzdec_cmd_fifo.sv]
// ----------------------------------------------------------------------------
// lzdec_cmd_fifo
// Short command queue between parser and copy engine.
// ----------------------------------------------------------------------------
module lzdec_cmd_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  lzdec_pkg::cmd_t push_cmd,
	output logic            full,
	input  logic            pop,
	output lzdec_pkg::cmd_t pop_cmd,
	output logic            empty
);

	localparam int PW = $clog2(lzdec_pkg::CMD_FIFO_DEPTH);

	lzdec_pkg::cmd_t mem_q [lzdec_pkg::CMD_FIFO_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [PW:0]     count_q;

	assign full    = count_q == (PW+1)'(lzdec_pkg::CMD_FIFO_DEPTH);
	assign empty   = count_q == '0;
	assign pop_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[hw/rtl/lzdec_back.sv]
// ----------------------------------------------------------------------------
// lzdec_back
// Copy engine: executes queued tokens against the history window, packs
// decoded bytes into result words and holds them in the output register.
// ----------------------------------------------------------------------------
module lzdec_back #(
	parameter int HISTORY_DEPTH    = lzdec_pkg::DEF_HISTORY_DEPTH,
	parameter int BYTES_PER_RESULT = lzdec_pkg::DEF_BYTES_PER_RESULT
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            fifo_empty,
	input  lzdec_pkg::cmd_t fifo_cmd,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [31:0]     out_data,
	output logic [2:0]      byte_count,
	output logic            last_of_run,
	output logic [1:0]      status
);

	localparam int AW    = $clog2(HISTORY_DEPTH);
	localparam int PW    = $clog2(HISTORY_DEPTH + 1);
	localparam int LANES = (BYTES_PER_RESULT < 1) ? 1 :
		((BYTES_PER_RESULT > lzdec_pkg::MAX_LANES) ? lzdec_pkg::MAX_LANES : BYTES_PER_RESULT);
	localparam int CW    = lzdec_pkg::CMP_W;

	lzdec_pkg::back_state_t state_q, state_d;
	lzdec_pkg::cmd_t        cmd_q, cmd_d;

	logic [AW-1:0] wp_q;
	logic [PW-1:0] prod_q;
	logic [7:0]    last_byte_q;
	logic [AW-1:0] rp_q, rp_d, rp_inc;
	logic [7:0]    left_q, left_d;
	logic          pend_q, pend_d;
	logic          off1_q, off1_d;
	logic [31:0]   acc_q, acc_d;
	logic [2:0]    cnt_q, cnt_d;

	logic          out_valid_q;
	logic [31:0]   out_data_q;
	logic [2:0]    byte_count_q;
	logic          last_q;
	lzdec_pkg::status_t status_q;

	logic          adv;
	logic          put;
	logic [7:0]    put_byte;
	logic          stream_rst;
	logic          load_out;
	logic [31:0]   od_d;
	logic [2:0]    bc_d;
	logic          lr_d;
	lzdec_pkg::status_t st_d;

	logic          ram_re;
	logic [7:0]    ram_rdata;

	logic          off_zero;
	logic          len_zero;
	logic          off_bad;
	logic [CW-1:0] src_diff;
	logic [CW-1:0] src_wrap;
	logic [7:0]    copy_byte;
	logic          copy_last;
	logic [2:0]    new_cnt;
	logic [31:0]   pack_data;

	lzdec_ram #(
		.WIDTH (8),
		.DEPTH (HISTORY_DEPTH)
	) u_history (
		.clk   (clk),
		.we    (put),
		.waddr (wp_q),
		.wdata (put_byte),
		.re    (ram_re),
		.raddr (rp_q),
		.rdata (ram_rdata)
	);

	assign adv = !out_valid_q || !out_stall;

	assign off_zero = cmd_q.offset == '0;
	assign len_zero = cmd_q.data == '0;
	assign off_bad  = off_zero || (CW'(cmd_q.offset) > CW'(prod_q));

	// source = write pointer - offset, modulo window size
	assign src_diff = CW'(wp_q) - CW'(cmd_q.offset);
	assign src_wrap = src_diff[CW-1] ? (src_diff + CW'(HISTORY_DEPTH)) : src_diff;

	assign rp_inc = (rp_q == AW'(HISTORY_DEPTH - 1)) ? '0 : rp_q + 1'b1;

	// offset 1 reads the byte written in the same cycle: take it from the register
	assign copy_byte = off1_q ? last_byte_q : ram_rdata;
	assign copy_last = left_q == '0;
	assign new_cnt   = cnt_q + 3'd1;
	assign pack_data = acc_q | (32'(copy_byte) << {cnt_q[1:0], 3'b000});

	always_comb begin
		state_d    = state_q;
		cmd_d      = cmd_q;
		pop        = 1'b0;
		put        = 1'b0;
		put_byte   = cmd_q.data;
		stream_rst = 1'b0;
		load_out   = 1'b0;
		od_d       = '0;
		bc_d       = '0;
		lr_d       = 1'b0;
		st_d       = lzdec_pkg::ST_OK;
		rp_d       = rp_q;
		left_d     = left_q;
		pend_d     = pend_q;
		off1_d     = off1_q;
		acc_d      = acc_q;
		cnt_d      = cnt_q;
		ram_re     = 1'b0;

		unique case (state_q)
			lzdec_pkg::BK_IDLE: begin
				if (!fifo_empty) begin
					pop     = 1'b1;
					cmd_d   = fifo_cmd;
					state_d = lzdec_pkg::BK_EXEC;
				end
			end
			lzdec_pkg::BK_EXEC: begin
				unique case (cmd_q.kind)
					lzdec_pkg::CMD_NOP: begin
						stream_rst = cmd_q.eos;
						state_d    = lzdec_pkg::BK_IDLE;
					end
					lzdec_pkg::CMD_LIT: begin
						if (adv) begin
							put        = 1'b1;
							load_out   = 1'b1;
							od_d       = 32'(cmd_q.data);
							bc_d       = 3'd1;
							lr_d       = 1'b1;
							stream_rst = cmd_q.eos;
							state_d    = lzdec_pkg::BK_IDLE;
						end
					end
					lzdec_pkg::CMD_FAULT: begin
						if (adv) begin
							load_out   = 1'b1;
							st_d       = cmd_q.status;
							lr_d       = 1'b1;
							stream_rst = cmd_q.eos;
							state_d    = lzdec_pkg::BK_IDLE;
						end
					end
					lzdec_pkg::CMD_MATCH: begin
						if (off_zero && len_zero) begin
							// empty match stands for a zero byte
							if (adv) begin
								put        = 1'b1;
								put_byte   = '0;
								load_out   = 1'b1;
								bc_d       = 3'd1;
								lr_d       = 1'b1;
								stream_rst = cmd_q.eos;
								state_d    = lzdec_pkg::BK_IDLE;
							end
						end else if (off_bad) begin
							if (adv) begin
								load_out   = 1'b1;
								st_d       = lzdec_pkg::ST_BAD_REF;
								lr_d       = 1'b1;
								stream_rst = cmd_q.eos;
								state_d    = lzdec_pkg::BK_IDLE;
							end
						end else if (len_zero) begin
							stream_rst = cmd_q.eos;
							state_d    = lzdec_pkg::BK_IDLE;
						end else begin
							rp_d    = src_wrap[AW-1:0];
							left_d  = cmd_q.data;
							pend_d  = 1'b0;
							off1_d  = cmd_q.offset == 16'd1;
							acc_d   = '0;
							cnt_d   = '0;
							state_d = lzdec_pkg::BK_COPY;
						end
					end
				endcase
			end
			lzdec_pkg::BK_COPY: begin
				if (adv) begin
					// read one byte ahead, write the byte fetched by the previous read
					if (left_q != '0) begin
						ram_re = 1'b1;
						rp_d   = rp_inc;
						left_d = left_q - 8'd1;
						pend_d = 1'b1;
					end else begin
						pend_d = 1'b0;
					end
					if (pend_q) begin
						put      = 1'b1;
						put_byte = copy_byte;
						if (new_cnt == 3'(LANES) || copy_last) begin
							load_out = 1'b1;
							od_d     = pack_data;
							bc_d     = new_cnt;
							lr_d     = copy_last;
							acc_d    = '0;
							cnt_d    = '0;
						end else begin
							acc_d = pack_data;
							cnt_d = new_cnt;
						end
						if (copy_last) begin
							stream_rst = cmd_q.eos;
							state_d    = lzdec_pkg::BK_IDLE;
						end
					end
				end
			end
			default: begin
				state_d = lzdec_pkg::BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lzdec_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q     <= '0;
			prod_q   <= '0;
			left_q   <= '0;
			pend_q   <= 1'b0;
			cnt_q    <= '0;
			acc_q    <= '0;
		end else begin
			left_q <= left_d;
			pend_q <= pend_d;
			cnt_q  <= cnt_d;
			acc_q  <= acc_d;
			if (stream_rst) begin
				wp_q   <= '0;
				prod_q <= '0;
			end else if (put) begin
				wp_q <= (wp_q == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_q + 1'b1;
				if (prod_q != PW'(HISTORY_DEPTH)) begin
					prod_q <= prod_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		cmd_q  <= cmd_d;
		rp_q   <= rp_d;
		off1_q <= off1_d;
		if (put) begin
			last_byte_q <= put_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data_q   <= od_d;
			byte_count_q <= bc_d;
			last_q       <= lr_d;
			status_q     <= st_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_data    = out_data_q;
	assign byte_count  = byte_count_q;
	assign last_of_run = last_q;
	assign status      = status_q;

endmodule

[hw/rtl/lz77_token_stream_decoder_core.sv]
// A literal or fault result passes the command queue, the copy engine's command register
// and the output register; a match's first word also waits for history reads and packing.
// Throughput: parser takes one byte per cycle while the 4-entry command queue is not full.
// Copy engine: takes one queued token at a time and finishes it before popping the next.
// Words carry up to BYTES_PER_RESULT (clamped to 1..4) bytes; output stall holds the copy engine.
// Reset clears parser, queue, write pointer and output valid; history RAM is not cleared.
// ----------------------------------------------------------------------------
// lz77_token_stream_decoder_core
// LZ77 token stream decoder with a sliding history window: parser front end,
// command queue and copy engine.
// ----------------------------------------------------------------------------
module lz77_token_stream_decoder_core #(
	parameter int HISTORY_DEPTH    = lzdec_pkg::DEF_HISTORY_DEPTH,
	parameter int BYTES_PER_RESULT = lzdec_pkg::DEF_BYTES_PER_RESULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	input  logic        end_of_stream,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] out_data,
	output logic [2:0]  byte_count,
	output logic        last_of_run,
	output logic [1:0]  status
);

	logic            push;
	lzdec_pkg::cmd_t push_cmd;
	logic            fifo_full;
	logic            pop;
	lzdec_pkg::cmd_t pop_cmd;
	logic            fifo_empty;

	lzdec_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.in_byte       (in_byte),
		.end_of_stream (end_of_stream),
		.push          (push),
		.push_cmd      (push_cmd),
		.fifo_full     (fifo_full)
	);

	lzdec_cmd_fifo u_cmd_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (fifo_full),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.empty    (fifo_empty)
	);

	lzdec_back #(
		.HISTORY_DEPTH    (HISTORY_DEPTH),
		.BYTES_PER_RESULT (BYTES_PER_RESULT)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.fifo_empty  (fifo_empty),
		.fifo_cmd    (pop_cmd),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data),
		.byte_count  (byte_count),
		.last_of_run (last_of_run),
		.status      (status)
	);

endmodule

[sim/lz77_token_stream_decoder_core_tb.sv]
// ----------------------------------------------------------------------------
// lz77_token_stream_decoder_core_tb
// Self-checking bench for the LZ77 token decoder. A directed table covers
// literals, the zero/zero match, overlapping copies, bad references, bad tags,
// the halted state and truncated tokens. Random token streams follow. Every
// output word is checked against the table or a behavioral decoder kept in the bench.
// ----------------------------------------------------------------------------
module lz77_token_stream_decoder_core_tb;

	localparam int LANES = (lzdec_pkg::DEF_BYTES_PER_RESULT < 1) ? 1 :
		(lzdec_pkg::DEF_BYTES_PER_RESULT > lzdec_pkg::MAX_LANES) ? lzdec_pkg::MAX_LANES :
		lzdec_pkg::DEF_BYTES_PER_RESULT;
	localparam int RANDOM_ITEMS = 184;
	localparam int QUIET_FROM   = 150;
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int REPORT_MAX   = 10;
	localparam int N_ROWS       = 26;
	localparam int STEP_MAX     = 66;
	localparam int PEND_DEPTH   = 1024;

	typedef struct packed {
		logic [31:0]         data;
		logic [2:0]          count;
		logic                last;
		lzdec_pkg::status_t  st;
	} word_t;

	// typed = 1: row causes exactly one word, given here
	typedef struct packed {
		logic [7:0]          b;
		logic                eos;
		logic                typed;
		logic [31:0]         data;
		logic [2:0]          count;
		lzdec_pkg::status_t  st;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  in_byte = 8'h00;
	logic        end_of_stream = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] out_data;
	logic [2:0]  byte_count;
	logic        last_of_run;
	logic [1:0]  status;

	// decoder model state
	logic [7:0]         hist_mem [0:lzdec_pkg::DEF_HISTORY_DEPTH-1];
	logic [15:0]        wr_ptr = '0;
	logic [16:0]        produced = '0;
	lzdec_pkg::phase_t  phase = lzdec_pkg::PH_TAG;
	logic [7:0]         off_lo = '0;
	logic [7:0]         off_hi = '0;
	logic               halted = 1'b0;
	logic [31:0]        pack_acc;
	int                 pack_n;

	// words of one step, and words still owed by the block
	word_t       step_buf [STEP_MAX];
	int          step_n = 0;
	word_t       pend_buf [PEND_DEPTH];
	int          pend_wr = 0;
	int          pend_rd = 0;

	int          mismatches = 0;
	int          idle_pct = 30;
	int          stall_pct = 30;
	int          stall_left = 0;
	int unsigned cycles = 0;

	row_t dir_rows [N_ROWS] = '{
		'{8'h00, 1'b0, 1'b0, 32'h0, 3'd0, lzdec_pkg::ST_OK},
		'{8'hFF, 1'b0, 1'b1, 32'hFF, 3'd1, lzdec_pkg::ST_OK},
		'{8'h01, 1'b0, 1'b0, 32'h0, 3'd0, lzdec_pkg::ST_OK},
		'{8'h00, 1'b0, 1'b0, 32'h0, 3'd0, lzdec_pkg::ST_OK},
		'{8'h00, 1'b0, 1'b0, 32'h0, 3'd0, lzdec_pkg::ST_OK},
		'{8'h00, 1'b0, 1'b1, 32'h0, 3'd1, lzdec_pkg::ST_OK},
		// offset 2, length 255: overlapping copy, longest run of words
		'{8'h01, 1'b0, 1'b0, 32'h0, 3'd0, lzdec_pkg::ST_OK},
		'{8'h02, 1'b0, 1'b0, 32'h0, 3'd0, lzdec_pkg::ST_OK},
		'{8'h00, 1'b0, 1'b0, 32'h0, 3'd0, lzdec_pkg::ST_OK},
		'{8'hFF, 1'b0, 1'b0, 32'h0, 3'd0, lzdec_pkg::ST_OK},
		// valid offset, zero length: nothing comes out
		'{8'h01, 1'b0, 1'b0, 32'h0, 3'd0, lzdec_pkg::ST_OK},
		'{8'h03, 1'b0, 1'b0, 32'h0, 3'd0, lzdec_pkg::ST_OK},
		'{8'h00, 1'b0, 1'b0, 32'h0, 3'd0, lzdec_pkg::ST_OK},
		'{8'h00, 1'b0, 1'b0, 32'h0, 3'd0, lzdec_pkg::ST_OK},
		'{8'h01, 1'b0, 1'b0, 32'h0, 3'd0, lzdec_pkg::ST_OK},
		'{8'h00, 1'b0, 1'b0, 32'h0, 3'd0, lzdec_pkg::ST_OK},
		'{8'h00, 1'b0, 1'b0, 32'h0, 3'd0, lzdec_pkg::ST_OK},
		'{8'h05, 1'b0, 1'b1, 32'h0, 3'd0, lzdec_pkg::ST_BAD_REF},
		// offset past produced bytes, closes the stream
		'{8'h01, 1'b0, 1'b0, 32'h0, 3'd0, lzdec_pkg::ST_OK},
		'{8'hFF, 1'b0, 1'b0, 32'h0, 3'd0, lzdec_pkg::ST_OK},
		'{8'hFF, 1'b0, 1'b0, 32'h0, 3'd0, lzdec_pkg::ST_OK},
		'{8'h01, 1'b1, 1'b1, 32'h0, 3'd0, lzdec_pkg::ST_BAD_REF},
		'{8'h07, 1'b0, 1'b1, 32'h0, 3'd0, lzdec_pkg::ST_BAD_TAG},
		'{8'h55, 1'b0, 1'b0, 32'h0, 3'd0, lzdec_pkg::ST_OK},
		'{8'h00, 1'b1, 1'b0, 32'h0, 3'd0, lzdec_pkg::ST_OK},
		'{8'h01, 1'b1, 1'b1, 32'h0, 3'd0, lzdec_pkg::ST_TRUNC}
	};

	lz77_token_stream_decoder_core #(
		.HISTORY_DEPTH(lzdec_pkg::DEF_HISTORY_DEPTH),
		.BYTES_PER_RESULT(lzdec_pkg::DEF_BYTES_PER_RESULT)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_byte(in_byte),
		.end_of_stream(end_of_stream),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.byte_count(byte_count),
		.last_of_run(last_of_run),
		.status(status)
	);

	always #5 clk = ~clk;

	function automatic void add_step_word(input word_t w);
		step_buf[step_n] = w;
		step_n++;
	endfunction

	function automatic void flush_pack();
		if (pack_n > 0) begin
			add_step_word(word_t'{pack_acc, 3'(pack_n), 1'b0, lzdec_pkg::ST_OK});
			pack_acc = '0;
			pack_n = 0;
		end
	endfunction

	function automatic void push_byte(input logic [7:0] b);
		hist_mem[wr_ptr] = b;
		wr_ptr = wr_ptr + 16'd1;
		if (produced < lzdec_pkg::DEF_HISTORY_DEPTH)
			produced = produced + 17'd1;
		pack_acc = pack_acc | (32'(b) << (8 * pack_n));
		pack_n++;
		if (pack_n >= LANES)
			flush_pack();
	endfunction

	function automatic void restart_stream();
		wr_ptr = '0;
		produced = '0;
		phase = lzdec_pkg::PH_TAG;
		off_lo = '0;
		off_hi = '0;
		halted = 1'b0;
	endfunction

	// fills step_buf with the words one input byte causes
	function automatic void decode_byte(input logic [7:0] b, input logic eos);
		logic [15:0] off;
		logic [15:0] idx;
		int k;
		step_n = 0;
		pack_acc = '0;
		pack_n = 0;
		if (halted) begin
			if (eos)
				restart_stream();
			return;
		end
		case (phase)
			lzdec_pkg::PH_TAG: begin
				if (b == lzdec_pkg::TAG_LITERAL)
					phase = lzdec_pkg::PH_LIT;
				else if (b == lzdec_pkg::TAG_MATCH)
					phase = lzdec_pkg::PH_OFF_LO;
				else begin
					halted = 1'b1;
					add_step_word(word_t'{32'h0, 3'd0, 1'b0, lzdec_pkg::ST_BAD_TAG});
				end
			end
			lzdec_pkg::PH_LIT: begin
				push_byte(b);
				phase = lzdec_pkg::PH_TAG;
			end
			lzdec_pkg::PH_OFF_LO: begin
				off_lo = b;
				phase = lzdec_pkg::PH_OFF_HI;
			end
			lzdec_pkg::PH_OFF_HI: begin
				off_hi = b;
				phase = lzdec_pkg::PH_LEN;
			end
			default: begin
				off = {off_hi, off_lo};
				if (off == 16'h0 && b == 8'h0)
					push_byte(8'h00);
				else if (off == 16'h0 || 17'(off) > produced)
					add_step_word(word_t'{32'h0, 3'd0, 1'b0, lzdec_pkg::ST_BAD_REF});
				else begin
					for (k = 0; k < int'(b); k++) begin
						idx = wr_ptr - off;
						push_byte(hist_mem[idx]);
					end
				end
				phase = lzdec_pkg::PH_TAG;
			end
		endcase
		flush_pack();
		if (eos) begin
			if (!halted && phase != lzdec_pkg::PH_TAG)
				add_step_word(word_t'{32'h0, 3'd0, 1'b0, lzdec_pkg::ST_TRUNC});
			restart_stream();
		end
		if (step_n > 0)
			step_buf[step_n - 1].last = 1'b1;
	endfunction

	function automatic void flag_mismatch(input string what, input word_t got, input word_t want);
		mismatches++;
		if (mismatches <= REPORT_MAX)
			$display("%s: got data=%h count=%0d last=%b status=%0d, expected data=%h count=%0d last=%b status=%0d",
				what, got.data, got.count, got.last, got.st,
				want.data, want.count, want.last, want.st);
	endfunction

	function automatic int pick_pct();
		int sel;
		sel = $urandom_range(2);
		return (sel == 0) ? 0 : (sel == 1) ? 25 : 60;
	endfunction

	// one byte transfer, then the model runs on it
	task automatic send_item(input logic [7:0] b, input logic eos,
			input logic typed = 1'b0, input word_t want = '0);
		int gap;
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			gap = $urandom_range(14, 1);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		end_of_stream <= eos;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		decode_byte(b, eos);
		if (typed) begin
			step_n = 0;
			add_step_word(want);
		end
		for (int i = 0; i < step_n; i++) begin
			pend_buf[pend_wr % PEND_DEPTH] = step_buf[i];
			pend_wr++;
		end
	endtask

	task automatic send_match(input logic [15:0] off, input logic [7:0] len, input logic eos);
		send_item(lzdec_pkg::TAG_MATCH, 1'b0);
		send_item(off[7:0], 1'b0);
		send_item(off[15:8], 1'b0);
		send_item(len, eos);
	endtask

	// output side: check each transfer, then choose the next stall
	always @(posedge clk or negedge arst_n) begin
		word_t got;
		word_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				got = word_t'{out_data, byte_count, last_of_run, lzdec_pkg::status_t'(status)};
				if (pend_rd == pend_wr)
					flag_mismatch("UNEXPECTED WORD", got, '0);
				else begin
					want = pend_buf[pend_rd % PEND_DEPTH];
					pend_rd++;
					if (got.data !== want.data || got.count !== want.count ||
							got.last !== want.last || got.st !== want.st)
						flag_mismatch("MISMATCH", got, want);
				end
			end
			if (stall_left != 0) begin
				stall_left = stall_left - 1;
				out_stall <= 1'b1;
			end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
				stall_left = $urandom_range(13);
				out_stall <= 1'b1;
			end else
				out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin : stimulus
		int sent;
		int next_mode_at;
		int pick;
		int lsel;
		int len;
		int max_off;
		int trunc_len;
		int hold;
		logic eos_here;
		logic [15:0] off;

		sent = 0;
		next_mode_at = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < N_ROWS; r++)
			send_item(dir_rows[r].b, dir_rows[r].eos, dir_rows[r].typed,
				word_t'{dir_rows[r].data, dir_rows[r].count, 1'b1, dir_rows[r].st});

		while (sent < RANDOM_ITEMS) begin
			if (sent >= QUIET_FROM) begin
				idle_pct = 0;
				stall_pct = 0;
			end else if (sent >= next_mode_at) begin
				idle_pct = pick_pct();
				stall_pct = pick_pct();
				next_mode_at = sent + 30;
			end
			pick = $urandom_range(99);
			eos_here = ($urandom_range(99) < 6);
			if (pick < 40) begin
				send_item(lzdec_pkg::TAG_LITERAL, 1'b0);
				send_item(8'($urandom), eos_here);
				sent += 2;
			end else if (pick < 80) begin
				if (produced == 0)
					send_match(16'h0, 8'h0, eos_here);
				else begin
					max_off = (produced > 65535) ? 65535 : int'(produced);
					// short offsets give overlapping copies
					if ($urandom_range(1) != 0 && max_off > 4)
						max_off = 4;
					lsel = $urandom_range(99);
					len = (lsel < 80) ? $urandom_range(12) :
						(lsel < 95) ? $urandom_range(64, 13) : 255;
					send_match(16'($urandom_range(max_off, 1)), 8'(len), eos_here);
				end
				sent += 4;
			end else if (pick < 88) begin
				if (produced < 65535 && $urandom_range(1) != 0) begin
					off = 16'($urandom_range(65535, int'(produced) + 1));
					len = $urandom_range(255);
				end else begin
					off = 16'h0;
					len = $urandom_range(255, 1);
				end
				send_match(off, 8'(len), eos_here);
				sent += 4;
			end else if (pick < 94) begin
				// token cut short by end of stream
				if ($urandom_range(1) != 0) begin
					send_item(lzdec_pkg::TAG_LITERAL, 1'b1);
					sent += 1;
				end else begin
					trunc_len = $urandom_range(3, 1);
					send_item(lzdec_pkg::TAG_MATCH, trunc_len == 1);
					for (int k = 2; k <= trunc_len; k++)
						send_item(8'($urandom), k == trunc_len);
					sent += trunc_len;
				end
			end else if (pick < 97) begin
				send_item(8'($urandom_range(255, 2)), 1'b0);
				// halted: these are dropped until end of stream
				hold = $urandom_range(3);
				for (int k = 0; k < hold; k++)
					send_item(8'($urandom), 1'b0);
				send_item(8'($urandom), 1'b1);
				sent += hold + 2;
			end else begin
				send_item(8'($urandom), $urandom_range(99) < 20);
				sent += 1;
			end
		end
		in_valid <= 1'b0;
		end_of_stream <= 1'b0;

		while (pend_rd != pend_wr)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
